### rtl/keyed_class_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed class priority queue
// Clocked implication checks used by the file that asserts.
// ----------------------------------------------------------------------------
`ifndef KEYED_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define KEYED_CLASS_PRIORITY_QUEUE_MACROS_SVH
// Check that a condition implies another at the same edge
`define KCPQ_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("kcpq check failed");
// Check that a condition implies another at the next edge
`define KCPQ_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("kcpq check failed");
`endif

### rtl/kcpq_pkg.sv
// ----------------------------------------------------------------------------
// kcpq_pkg
// Types and constants shared by the keyed class priority queue.
// ----------------------------------------------------------------------------
package kcpq_pkg;
    localparam int Depth = 64;
    localparam int KeyBits = 16;
    localparam int ClassCount = 4;
    localparam int PrioBits = 16;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CHANGE = 3'd2,
        CMD_POP    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EQUAL     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] key;
        logic [1:0]  req_class;
        logic [15:0] priority_req;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        was_removed;
        logic [15:0] front_key;
        logic [1:0]  front_class;
        logic        is_empty;
    } out_word_t;

    // One stored entry; cells are kept sorted, front at cell 0.
    typedef struct packed {
        logic                vld;
        logic [KeyBits-1:0]  key;
        logic [1:0]          cls;
        logic [PrioBits-1:0] prio;
    } entry_t;

    // Broadcast operation to all cells.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_DEL    = 3'd1,
        OP_INS    = 3'd2,
        OP_POP    = 3'd3,
        OP_CLR    = 3'd4
    } op_t;

    typedef struct packed {
        op_t    op;
        entry_t ent;
    } bcast_t;

    // Per-cell match flags reported back.
    typedef struct packed {
        logic key_hit;
        logic eq_hit;
        logic cls_diff;
    } flags_t;

    // Strict order: a before b.
    function automatic logic before_f(entry_t a, entry_t b);
        return (a.cls < b.cls) || ((a.cls == b.cls) && (a.prio > b.prio));
    endfunction
endpackage

### rtl/kcpq_cell.sv
// ----------------------------------------------------------------------------
// kcpq_cell
// One slot of the sorted chain: compares against the broadcast entry and
// shifts toward or away from the front.
// ----------------------------------------------------------------------------
module kcpq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  kcpq_pkg::bcast_t bc,
    input  kcpq_pkg::entry_t prev_ent,
    input  logic            prev_before,
    input  logic            prev_key_seen,
    input  kcpq_pkg::entry_t next_ent,
    output kcpq_pkg::entry_t ent,
    output logic            is_before,
    output logic            key_seen,
    output kcpq_pkg::flags_t flags
);
    import kcpq_pkg::*;

    entry_t ent_reg, ent_next;
    logic   mine_before;
    logic   key_hit;

    assign ent = ent_reg;
    assign key_hit = ent_reg.vld && (ent_reg.key == bc.ent.key);
    // Valid entries ahead of the new one stay; invalid cells sort last.
    assign mine_before = ent_reg.vld && before_f(ent_reg, bc.ent);
    assign is_before = mine_before;
    assign key_seen = prev_key_seen || key_hit;
    assign flags.key_hit = key_hit;
    assign flags.eq_hit = ent_reg.vld && (ent_reg.cls == bc.ent.cls)
                          && (ent_reg.prio == bc.ent.prio);
    assign flags.cls_diff = key_hit && (ent_reg.cls != bc.ent.cls);

    // Shift or hold according to the broadcast operation
    always_comb
    begin
        ent_next = ent_reg;
        unique case (bc.op)
            OP_DEL:
            begin
                if (key_seen)
                    ent_next = next_ent;
            end
            OP_INS:
            begin
                if (!mine_before)
                begin
                    if (prev_before)
                        ent_next = bc.ent;
                    else
                        ent_next = prev_ent;
                end
            end
            OP_POP:
                ent_next = next_ent;
            OP_CLR:
                ent_next.vld = 1'b0;
            default:
                ent_next = ent_reg;
        endcase
    end

    // Hold the slot; reset empties it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else
            ent_reg <= ent_next;
    end
endmodule

### rtl/keyed_class_priority_queue.sv
// ----------------------------------------------------------------------------
// Keyed class priority queue
// Input channel in/in_valid/in_stall carries one command word; output
// channel out/out_valid/out_stall returns one result word per command.
// The store is a sorted chain of 64 cells with the front at cell 0, so
// the front key and class are read straight from the first cell.
// Each command runs through a small sequencer: a lookup cycle that
// gathers the per-cell flags and shifts the chain for pop or clear, an
// optional delete-shift cycle, an optional insert-shift cycle, and a
// result cycle that loads the result word; the sequencer then returns to
// idle to take the next command, so one is in flight at a time. A new
// command is taken while the previous result waits in the output
// register, and its own result is held back until that is free.
// Reset clears every cell at once, so the queue is empty and ready once
// reset is released. A stalled receiver holds the result word stable.
// ----------------------------------------------------------------------------
module keyed_class_priority_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  kcpq_pkg::in_word_t  in,
    input  logic                in_valid,
    output logic                in_stall,
    output kcpq_pkg::out_word_t out,
    output logic                out_valid,
    input  logic                out_stall
);
    import kcpq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_DEL  = 5'b00100,
        S_INS  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t    state_reg, state_next;
    in_word_t  cmd_reg, cmd_next;
    logic [2:0] status_reg, status_next;
    logic      rem_reg, rem_next;
    out_word_t out_reg, out_next;
    logic      ov_reg, ov_next;

    bcast_t    bc;
    entry_t    ents [Depth];
    logic      befores [Depth];
    logic      seens [Depth];
    flags_t    flg [Depth];
    logic [Depth-1:0] key_v, eq_v, diff_v, vld_v;
    entry_t    newent;
    entry_t    empty_ent;

    assign empty_ent = '0;

    // Build the broadcast entry from the held command
    always_comb
    begin
        newent.vld  = 1'b1;
        newent.key  = cmd_reg.key;
        newent.cls  = cmd_reg.req_class;
        newent.prio = cmd_reg.priority_req;
    end

    // Build the chain
    for (genvar i = 0; i < Depth; i++)
    begin : g_cell
        kcpq_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .bc           (bc),
            .prev_ent     ((i == 0) ? empty_ent : ents[(i == 0) ? 0 : i-1]),
            .prev_before  ((i == 0) ? 1'b1 : befores[(i == 0) ? 0 : i-1]),
            .prev_key_seen((i == 0) ? 1'b0 : seens[(i == 0) ? 0 : i-1]),
            .next_ent     ((i == Depth-1) ? empty_ent
                                          : ents[(i == Depth-1) ? i : i+1]),
            .ent          (ents[i]),
            .is_before    (befores[i]),
            .key_seen     (seens[i]),
            .flags        (flg[i])
        );
        assign key_v[i]  = flg[i].key_hit;
        assign eq_v[i]   = flg[i].eq_hit;
        assign diff_v[i] = flg[i].cls_diff;
        assign vld_v[i]  = ents[i].vld;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out = out_reg;
    assign out_valid = ov_reg;

    // Sequence one command through lookup, delete, insert and result
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        rem_next    = rem_reg;
        out_next    = out_reg;
        ov_next     = ov_reg && out_stall;
        bc.op       = OP_NONE;
        bc.ent      = newent;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in;
                    if (in.req_class > 2'(ClassCount-1))
                        cmd_next.req_class = 2'(ClassCount-1);
                    status_next = ST_OK;
                    rem_next    = 1'b0;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DONE;
                priority case (cmd_reg.command)
                    CMD_ADD:
                    begin
                        if (|key_v)
                        begin
                            rem_next = 1'b1;
                            state_next = S_DEL;
                        end
                        else
                            state_next = S_INS;
                    end
                    CMD_REMOVE:
                    begin
                        if (|key_v)
                        begin
                            rem_next = 1'b1;
                            state_next = S_DEL;
                        end
                        else
                            status_next = ST_NOT_FOUND;
                    end
                    CMD_CHANGE:
                    begin
                        if (!(|key_v))
                            status_next = ST_NOT_FOUND;
                        else if (|diff_v)
                        begin
                            rem_next = 1'b1;
                            state_next = S_DEL;
                        end
                    end
                    CMD_POP:
                    begin
                        if (!ents[0].vld)
                            status_next = ST_EMPTY;
                        else
                        begin
                            bc.op = OP_POP;
                            rem_next = 1'b1;
                        end
                    end
                    CMD_CLEAR:
                        bc.op = OP_CLR;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_DEL:
            begin
                bc.op = OP_DEL;
                if (cmd_reg.command == CMD_REMOVE)
                    state_next = S_DONE;
                else
                    state_next = S_INS;
            end
            S_INS:
            begin
                state_next = S_DONE;
                if (|eq_v)
                    status_next = ST_EQUAL;
                else if (&vld_v)
                    status_next = ST_FULL;
                else
                    bc.op = OP_INS;
            end
            S_DONE:
            begin
                if (!ov_next)
                begin
                    out_next.status      = status_reg;
                    out_next.was_removed = rem_reg;
                    out_next.is_empty    = !ents[0].vld;
                    out_next.front_key   = ents[0].vld ? ents[0].key : '0;
                    out_next.front_class = ents[0].vld ? ents[0].cls : '0;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        rem_reg    <= rem_next;
        out_reg    <= out_next;
    end

`include "keyed_class_priority_queue_macros.svh"

    `KCPQ_ASSERT_IMP(a_front_empty, out_valid, out.is_empty == (out.front_key == 16'd0 && out.front_class == 2'd0) || !out.is_empty)
    `KCPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out))
    `KCPQ_ASSERT_IMP(a_key_unique, state_reg == S_LOOK, $countones(key_v) <= 1)
    `KCPQ_ASSERT_IMP(a_full_front, &vld_v, ents[0].vld)
endmodule
